/* sv/npcs_pkg.sv */
// Package for the nearest palette color search: payload types, palette ROM.
// No dependencies.
`default_nettype none
package npcs_pkg;

  localparam int RomSize        = 256;
  localparam int PaletteEntries = 256;
  localparam int DistW          = 10;
  localparam int IdxW           = 8;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic [7:0] best_index;
    logic [9:0] best_distance;
  } res_t;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [DistW-1:0] mdist;
  } cand_t;

  localparam logic [23:0] PalRom [RomSize] = '{
    24'h000000,24'hFF0000,24'hFFFF00,24'h00FF00,24'h00FFFF,24'h0000FF,24'hFF00FF,24'hFFFFFF,
    24'h808080,24'hC0C0C0,
    24'hFF0000,24'hFF7F7F,24'hA50000,24'hA55252,24'h7F0000,24'h7F3F3F,24'h4C0000,24'h4C2626,
    24'h260000,24'h261313,
    24'hFF3F00,24'hFF9F7F,24'hA52900,24'hA56752,24'h7F1F00,24'h7F4F3F,24'h4C1300,24'h4C2F26,
    24'h260900,24'h261C13,
    24'hFF7F00,24'hFFBF7F,24'hA55200,24'hA57C52,24'h7F3F00,24'h7F5F3F,24'h4C2600,24'h4C3926,
    24'h261300,24'h261C13,
    24'hFFBF00,24'hFFDF7F,24'hA57C00,24'hA59152,24'h7F5F00,24'h7F6F3F,24'h4C3900,24'h4C4226,
    24'h261C00,24'h262113,
    24'hFFFF00,24'hFFFF7F,24'hA5A500,24'hA5A552,24'h7F7F00,24'h7F7F3F,24'h4C4C00,24'h4C4C26,
    24'h262600,24'h262613,
    24'hBFFF00,24'hDFFF7F,24'h7CA500,24'h91A552,24'h5F7F00,24'h6F7F3F,24'h394C00,24'h424C26,
    24'h1C2600,24'h212613,
    24'h7FFF00,24'hBFFF7F,24'h52A500,24'h7CA552,24'h3F7F00,24'h5F7F3F,24'h264C00,24'h394C26,
    24'h132600,24'h1C2613,
    24'h3FFF00,24'h9FFF7F,24'h29A500,24'h67A552,24'h1F7F00,24'h4F7F3F,24'h134C00,24'h2F4C26,
    24'h092600,24'h172613,
    24'h00FF00,24'h7DFF7F,24'h00A500,24'h52A552,24'h007F00,24'h3F7F3F,24'h004C00,24'h264C26,
    24'h002600,24'h132613,
    24'h00FF3F,24'h7FFF9F,24'h00A529,24'h52A567,24'h007F1F,24'h3F7F4F,24'h004C13,24'h264C2F,
    24'h002609,24'h135817,
    24'h00FF7F,24'h7FFFBF,24'h00A552,24'h52A57C,24'h007F3F,24'h3F7F5F,24'h004C26,24'h264C39,
    24'h002613,24'h13581C,
    24'h00FFBF,24'h7FFFDF,24'h00A57C,24'h52A591,24'h007F5F,24'h3F7F6F,24'h004C39,24'h264C42,
    24'h00261C,24'h135858,
    24'h00FFFF,24'h7FFFFF,24'h00A5A5,24'h52A5A5,24'h007F7F,24'h3F7F7F,24'h004C4C,24'h264C4C,
    24'h002626,24'h135858,
    24'h00BFFF,24'h7FDFFF,24'h007CA5,24'h5291A5,24'h005F7F,24'h3F6FD9,24'h00394C,24'h26427E,
    24'h001C26,24'h135858,
    24'h007FFF,24'h7FBFFF,24'h0052A5,24'h527CA5,24'h003F7F,24'h3F5F7F,24'h00264C,24'h26397E,
    24'h001326,24'h131C58,
    24'h003FFF,24'h7F9FFF,24'h0029A5,24'h5267A5,24'h001F7F,24'h3F4F7F,24'h00134C,24'h262F7E,
    24'h000926,24'h131758,
    24'h0000FF,24'h7F7FFF,24'h0000A5,24'h5252A5,24'h00007F,24'h3F3F7F,24'h00004C,24'h26267E,
    24'h000026,24'h131358,
    24'h3F00FF,24'h9F7FFF,24'h2900A5,24'h6752A5,24'h1F007F,24'h4F3F7F,24'h13004C,24'h2F267E,
    24'h090026,24'h171358,
    24'h7F00FF,24'hBF7FFF,24'hA50052,24'h7C52A5,24'h3F007F,24'h5F3F7F,24'h26004C,24'h39267E,
    24'h130026,24'h1C1358,
    24'hBF00FF,24'hDF7FFF,24'h7C00A5,24'h8E52A5,24'h5F007F,24'h6F3F7F,24'h39004C,24'h42264C,
    24'h1C0026,24'h581358,
    24'hFF00FF,24'hFF7FFF,24'hA500A5,24'hA552A5,24'h7F007F,24'h7F3F7F,24'h4C004C,24'h4C264C,
    24'h260026,24'h581358,
    24'hFF00BF,24'hFF7FDF,24'hA5007C,24'hA55291,24'h7F005F,24'h7F3F6F,24'h4C0039,24'h4C2642,
    24'h26001C,24'h581358,
    24'hFF007F,24'hFF7FBF,24'hA50052,24'hA5527C,24'h7F003F,24'h7F3F5F,24'h4C0026,24'h4C2639,
    24'h260013,24'h58131C,
    24'hFF003F,24'hFF7F9F,24'hA50029,24'hA55267,24'h7F001F,24'h7F3F4F,24'h4C0013,24'h4C262F,
    24'h260009,24'h581317,
    24'h000000,24'h656565,24'h666666,24'h999999,24'hCCCCCC,24'hFFFFFF
  };

  // Lower index wins a tie: caller passes the lower-index candidate as a.
  function automatic cand_t pick(input cand_t a, input cand_t b);
    pick = (b.mdist < a.mdist) ? b : a;
  endfunction

endpackage
`default_nettype wire

/* sv/npcs_dist.sv */
// Distance stage: Manhattan distance from one pixel to every palette entry.
// Depends on npcs_pkg.
`default_nettype none
module npcs_dist import npcs_pkg::*; #(
  parameter int N = PaletteEntries
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire pix_t pix,
  output logic [DistW-1:0] mdist [N]
);

  function automatic logic [8:0] ad(input logic [7:0] a, input logic [7:0] b);
    ad = (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
  endfunction

  for (genvar i = 0; i < N; i++) begin : g_d
    always_ff @(posedge clk) begin
      if (en) begin
        mdist[i] <= DistW'(ad(pix.red_in, PalRom[i][23:16]))
                  + DistW'(ad(pix.green_in, PalRom[i][15:8]))
                  + DistW'(ad(pix.blue_in, PalRom[i][7:0]));
      end
    end
  end

endmodule
`default_nettype wire

/* sv/npcs_min.sv */
// Min stage: a registered 4:1 reduction of candidates, lowest index on ties.
// Depends on npcs_pkg.
`default_nettype none
module npcs_min import npcs_pkg::*; #(
  parameter int NI = 4
) (
  input  wire logic  clk,
  input  wire logic  en,
  input  wire cand_t cin  [NI],
  output cand_t      cout [(NI+3)/4]
);

  localparam int NO = (NI + 3) / 4;

  for (genvar j = 0; j < NO; j++) begin : g_m
    cand_t acc;
    always_comb begin
      acc = cin[4*j];
      for (int k = 1; k < 4; k++) begin
        if (4*j + k < NI) acc = pick(acc, cin[4*j+k]);
      end
    end
    always_ff @(posedge clk) begin
      if (en) cout[j] <= acc;
    end
  end

endmodule
`default_nettype wire

/* sv/nearest_palette_color_search.sv */
// Nearest palette color search: Manhattan-distance minimum over the palette.
// Pipeline: one distance stage and four 4:1 minimum stages.
// Throughput one pixel per cycle; the pipeline halts as a whole on stall.
// Synchronous reset clears the valid bits only.
// Depends on npcs_pkg, npcs_dist, npcs_min.
`default_nettype none
module nearest_palette_color_search import npcs_pkg::*; #(
  parameter int PALETTE_ENTRIES = PaletteEntries
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire pix_t in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      out_data
);

  localparam int N  = (PALETTE_ENTRIES > RomSize) ? RomSize : PALETTE_ENTRIES;
  localparam int N1 = (N + 3) / 4;
  localparam int N2 = (N1 + 3) / 4;
  localparam int N3 = (N2 + 3) / 4;
  localparam int N4 = (N3 + 3) / 4;
  localparam int Stages = 5;

  logic [Stages-1:0] vld;
  logic              en;
  logic [DistW-1:0]  mdist [N];
  cand_t c0 [N];
  cand_t c1 [N1];
  cand_t c2 [N2];
  cand_t c3 [N3];
  cand_t c4 [N4];

  assign en        = !(vld[Stages-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Stages-2:0], in_valid};
    end
  end

  npcs_dist #(.N(N)) u_dist (.clk, .en, .pix(in_data), .mdist);

  for (genvar i = 0; i < N; i++) begin : g_c
    assign c0[i].idx   = IdxW'(i);
    assign c0[i].mdist = mdist[i];
  end

  npcs_min #(.NI(N))  u_m1 (.clk, .en, .cin(c0), .cout(c1));
  npcs_min #(.NI(N1)) u_m2 (.clk, .en, .cin(c1), .cout(c2));
  npcs_min #(.NI(N2)) u_m3 (.clk, .en, .cin(c2), .cout(c3));
  npcs_min #(.NI(N3)) u_m4 (.clk, .en, .cin(c3), .cout(c4));

  assign out_data.best_index    = c4[0].idx;
  assign out_data.best_distance = c4[0].mdist;

endmodule
`default_nettype wire

/* sv/npcs_checker.sv */
// Port-level checks for nearest_palette_color_search, bound to the top level.
// Depends on npcs_pkg.
`default_nettype none
module npcs_checker import npcs_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire res_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.best_distance <= 10'd765)
    else $error("distance out of range");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");

endmodule

bind nearest_palette_color_search npcs_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
`default_nettype wire

/* sim/nearest_palette_color_search_tb.sv */
// Testbench for nearest_palette_color_search: directed table plus random pixels,
// checked against a palette minimum search. Depends on npcs_pkg and the block RTL.
`timescale 1ns / 1ps
module nearest_palette_color_search_tb;
  import npcs_pkg::*;

  localparam int NumRandom = 700;
  localparam int QuietTail = 120;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    pix_t pix;
    logic known;
    res_t res;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  pix_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_data;

  res_t match_q[$];
  int   failures = 0;
  int   matched = 0;
  int   cycles = 0;
  bit   quiet = 1'b0;

  nearest_palette_color_search dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [9:0] chan_gap(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? 10'(a - b) : 10'(b - a);
  endfunction

  // Manhattan minimum; strict less-than keeps the lowest index on a tie.
  function automatic res_t nearest_color(input pix_t p);
    res_t best;
    logic [9:0] d;
    logic [23:0] c;
    int n;
    n = (PaletteEntries < RomSize) ? PaletteEntries : RomSize;
    c = PalRom[0];
    best.best_index = '0;
    best.best_distance = chan_gap(p.red_in, c[23:16]) + chan_gap(p.green_in, c[15:8])
                         + chan_gap(p.blue_in, c[7:0]);
    for (int i = 1; i < n; i++) begin
      c = PalRom[i];
      d = chan_gap(p.red_in, c[23:16]) + chan_gap(p.green_in, c[15:8])
          + chan_gap(p.blue_in, c[7:0]);
      if (d < best.best_distance) begin
        best.best_distance = d;
        best.best_index = 8'(i);
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Record expected result at each accepted input transfer.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) match_q.push_back(nearest_color(in_data));
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (match_q.size() == 0) begin
        $error("result with nothing expected: index %0d", out_data.best_index);
        failures++;
      end else begin
        want = match_q.pop_front();
        matched++;
        if (out_data.best_index !== want.best_index) begin
          $error("best_index expected %0d got %0d", want.best_index, out_data.best_index);
          failures++;
        end
        if (out_data.best_distance !== want.best_distance) begin
          $error("best_distance expected %0d got %0d",
                 want.best_distance, out_data.best_distance);
          failures++;
        end
      end
    end
  end

  // Receiver stalls in bursts.
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet || rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_pixel(input pix_t p);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
  endtask

  // Lets the last accepted transfer reach the queue before waiting for it to empty.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (match_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] nudge(input logic [7:0] v);
    int t;
    t = int'(v) + $urandom_range(0, 8) - 4;
    return (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : 8'(t);
  endfunction

  vec_t table_rows[$];

  initial begin
    pix_t p;
    logic [23:0] c;
    int kind;
    // Exact hits resolve to the first entry holding that color.
    table_rows = '{
      '{'{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 10'd0}},
      '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd7, 10'd0}},
      '{'{8'd255, 8'd0, 8'd0}, 1'b1, '{8'd1, 10'd0}},
      '{'{8'd255, 8'd127, 8'd127}, 1'b1, '{8'd11, 10'd0}},
      '{'{8'd101, 8'd101, 8'd101}, 1'b1, '{8'd251, 10'd0}},
      '{'{8'd0, 8'd0, 8'd255}, 1'b1, '{8'd5, 10'd0}},
      '{'{8'd255, 8'd0, 8'd255}, 1'b1, '{8'd6, 10'd0}},
      '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{8'd8, 10'd0}},
      '{'{8'd1, 8'd1, 8'd1}, 1'b0, '0},
      '{'{8'd254, 8'd254, 8'd254}, 1'b0, '0},
      '{'{8'd255, 8'd255, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd255, 8'd255}, 1'b0, '0},
      '{'{8'd200, 8'd10, 8'd90}, 1'b0, '0},
      '{'{8'd170, 8'd85, 8'd170}, 1'b0, '0},
      '{'{8'd64, 8'd192, 8'd32}, 1'b0, '0},
      '{'{8'd153, 8'd153, 8'd152}, 1'b0, '0},
      '{'{8'd102, 8'd101, 8'd102}, 1'b0, '0}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) begin
      if (table_rows[i].known && nearest_color(table_rows[i].pix) !== table_rows[i].res) begin
        $error("table row %0d: best_index expected %0d, best_distance expected %0d",
               i, table_rows[i].res.best_index, table_rows[i].res.best_distance);
        failures++;
      end
      send_pixel(table_rows[i].pix);
    end
    // Hold off until the pipeline has handed back every result.
    drain_results();

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - QuietTail) quiet = 1'b1;
      kind = $urandom_range(0, 9);
      c = PalRom[$urandom_range(0, RomSize - 1)];
      if (kind < 4) begin
        p = pix_t'($urandom());
      end else if (kind < 6) begin
        p = '{c[23:16], c[15:8], c[7:0]};
      end else if (kind < 9) begin
        p = '{nudge(c[23:16]), nudge(c[15:8]), nudge(c[7:0])};
      end else begin
        p = '{$urandom_range(0, 1) ? 8'd255 : 8'd0, $urandom_range(0, 1) ? 8'd255 : 8'd0,
              8'($urandom())};
      end
      send_pixel(p);
    end
    drain_results();
    repeat (20) @(posedge clk);

    $display("Checked %0d pixel results: palette hits, near misses, random and extreme colors,",
             matched);
    $display("with bursty source gaps and sink stalls, and one full drain mid-run.");
    if (failures == 0 && match_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* nearest_palette_color_search.f */
sv/npcs_pkg.sv
sv/npcs_dist.sv
sv/npcs_min.sv
sv/nearest_palette_color_search.sv
sv/npcs_checker.sv
sim/nearest_palette_color_search_tb.sv
